[hdl/gradient_noise_2d_assert.svh]
// ============================================================================
// gradient_noise_2d_assert.svh
// Assertion macros used by the gradient noise top-level design file.
// ============================================================================
`ifndef GRADIENT_NOISE_2D_ASSERT_SVH
`define GRADIENT_NOISE_2D_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define GN2D_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gradient noise assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define GN2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gradient noise assertion failed");
`else
`define GN2D_ASSERT_NOW(lbl, ante, cons)
`define GN2D_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/gn2d_pkg.sv]
// ============================================================================
// gn2d_pkg
// Constants, types and the quarter-sine evaluator for the gradient noise block.
// ============================================================================
package gn2d_pkg;

    localparam int ANGLE_BITS_DEF      = 10;
    localparam int COORD_FRAC_BITS_DEF = 16;
    localparam int NUM_STAGES          = 12;

    // Register index codes, taken from paddr[2].
    localparam logic REG_NOISE_SEED = 1'b0;

    // Hash multipliers.
    localparam logic [31:0] SEED_MUL_X = 32'd2654435761;
    localparam logic [31:0] SEED_MUL_Y = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

    // Taylor coefficients of sin(pi/2 * t) in Q30.
    localparam logic [63:0] C1_Q30 = 64'd1686629713;
    localparam logic [63:0] C3_Q30 = 64'd693598672;
    localparam logic [63:0] C5_Q30 = 64'd85569306;
    localparam logic [63:0] C7_Q30 = 64'd5026995;
    localparam logic [63:0] C9_Q30 = 64'd172272;

    // Per-corner stage enables, one per register stage inside the corner unit.
    typedef struct packed {
        logic c1;
        logic c2;
        logic c3;
        logic c4;
        logic c5;
        logic c6;
    } t_corner_adv;

    // sin(pi/2 * t), t in Q30 from 0 to 2^30, result in Q15 (0 to 32768).
    function automatic logic [16:0] f_quarter_sine(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] p;
        t2 = (t * t) >> 30;
        p  = C7_Q30 - ((t2 * C9_Q30) >> 30);
        p  = C5_Q30 - ((t2 * p) >> 30);
        p  = C3_Q30 - ((t2 * p) >> 30);
        p  = C1_Q30 - ((t2 * p) >> 30);
        p  = (t * p) >> 30;
        return 17'((p + 64'd16384) >> 15);
    endfunction

endpackage

[hdl/gn2d_corner.sv]
// ============================================================================
// gn2d_corner
// Lattice hash, gradient lookup and distance dot product for one cell corner.
// ============================================================================
module gn2d_corner #(
    parameter int ANGLE_BITS = gn2d_pkg::ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  gn2d_pkg::t_corner_adv i_adv,
    input  logic [31:0]          i_ax,
    input  logic [31:0]          i_by,
    input  logic signed [24:0]   i_dx,
    input  logic signed [24:0]   i_dy,
    output logic signed [28:0]   o_dot
);
    import gn2d_pkg::*;

    localparam int RB    = ANGLE_BITS - 2;
    localparam int SIN_N = 1 << RB;

    typedef logic [16:0] t_sin_tab [SIN_N + 1];

    function automatic t_sin_tab f_build_tab();
        t_sin_tab tab;
        for (int i = 0; i <= SIN_N; i++) begin
            tab[i] = f_quarter_sine(64'(i) << (30 - RB));
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_tab();

    logic [31:0]        r_am;
    logic [31:0]        r_am2;
    logic [31:0]        r_by;
    logic [31:0]        r_bm;
    logic [31:0]        r_h;
    logic signed [24:0] r_dx [1:4];
    logic signed [24:0] r_dy [1:4];
    logic [16:0]        r_s;
    logic [16:0]        r_c;
    logic [1:0]         r_q;
    logic signed [42:0] r_px;
    logic signed [42:0] r_py;

    logic [ANGLE_BITS-1:0] w_k;
    logic [RB-1:0]         w_r;
    logic signed [17:0]    w_s;
    logic signed [17:0]    w_c;
    logic signed [17:0]    w_gx;
    logic signed [17:0]    w_gy;
    logic signed [43:0]    w_sum;

    assign w_k = r_h[31 -: ANGLE_BITS];
    assign w_r = w_k[RB-1:0];
    assign w_s = $signed({1'b0, r_s});
    assign w_c = $signed({1'b0, r_c});

    always_comb begin
        case (r_q)
            2'd0: begin
                w_gx = w_s;
                w_gy = w_c;
            end
            2'd1: begin
                w_gx = w_c;
                w_gy = -w_s;
            end
            2'd2: begin
                w_gx = -w_s;
                w_gy = -w_c;
            end
            default: begin
                w_gx = -w_c;
                w_gy = w_s;
            end
        endcase
    end

    assign w_sum = 44'(r_px) + 44'(r_py) + 44'sd16384;

    always_ff @(posedge i_clk) begin
        if (i_adv.c1) begin
            r_am    <= 32'(i_ax * HASH_MUL_A);
            r_by    <= i_by;
            r_dx[1] <= i_dx;
            r_dy[1] <= i_dy;
        end
        if (i_adv.c2) begin
            r_bm    <= 32'((r_by ^ {r_am[15:0], r_am[31:16]}) * HASH_MUL_B);
            r_am2   <= r_am;
            r_dx[2] <= r_dx[1];
            r_dy[2] <= r_dy[1];
        end
        if (i_adv.c3) begin
            r_h     <= 32'((r_am2 ^ {r_bm[15:0], r_bm[31:16]}) * HASH_MUL_C);
            r_dx[3] <= r_dx[2];
            r_dy[3] <= r_dy[2];
        end
        if (i_adv.c4) begin
            // Cosine is the sine read at the mirrored position of the quarter turn.
            r_s     <= SIN_TAB[{1'b0, w_r}];
            r_c     <= SIN_TAB[(RB + 1)'(SIN_N) - {1'b0, w_r}];
            r_q     <= w_k[ANGLE_BITS-1 -: 2];
            r_dx[4] <= r_dx[3];
            r_dy[4] <= r_dy[3];
        end
        if (i_adv.c5) begin
            r_px <= r_dx[4] * w_gx;
            r_py <= r_dy[4] * w_gy;
        end
        if (i_adv.c6) begin
            o_dot <= 29'(w_sum >>> 15);
        end
    end

endmodule

[hdl/gradient_noise_2d.sv]
// ============================================================================
// gradient_noise_2d
// Two-dimensional gradient noise: one Q16.16 point in, one Q1.15 value out.
// ============================================================================
//
//  Channel   Direction  Payload                               Handshake
//  s_axis    in         tdata[31:0] x_coord, [63:32] y_coord  tvalid/tready
//  m_axis    out        tdata[15:0] noise_value               tvalid/tready
//  APB       in/out     noise_seed at byte address 0          psel/penable
//
//  One point is accepted every cycle while the output is not stalled. The
//  pipeline has twelve register stages: the floor split, three hash
//  multiplies, the sine table read, the gradient products, the dot rounding
//  and two blend steps of multiply then add, then final rounding.
//  Reset is synchronous and clears the stage valid bits, the seed and its products only.
//  Every stage holds its item while the stage after it is full and stalled,
//  so empty stages still fill and points are taken while a result waits.
//
module gradient_noise_2d #(
    parameter int ANGLE_BITS      = gn2d_pkg::ANGLE_BITS_DEF,
    parameter int COORD_FRAC_BITS = gn2d_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Point input: [31:0] x_coord, [63:32] y_coord.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    // Noise output: [15:0] noise_value.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gn2d_pkg::*;

    `include "gradient_noise_2d_assert.svh"

    // ------------------------------------------------------------------
    // Configuration. The seed products are formed once at the write, so the
    // hash path only sees them as constants.
    // ------------------------------------------------------------------
    logic [31:0] r_seed;
    logic [31:0] r_seed_x;
    logic [31:0] r_seed_y;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NOISE_SEED);
    assign prdata   = (paddr[2] == REG_NOISE_SEED) ? r_seed : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_seed_x <= '0;
            r_seed_y <= '0;
        end else if (w_cfg_wr) begin
            r_seed   <= pwdata;
            r_seed_x <= 32'(pwdata * SEED_MUL_X);
            r_seed_y <= 32'(pwdata * SEED_MUL_Y);
        end
    end

    // ------------------------------------------------------------------
    // Stage control. A stage advances when it is empty or when the stage
    // after it advances; the last stage advances on an output transfer.
    // ------------------------------------------------------------------
    logic [NUM_STAGES:1]   r_vld;
    logic [NUM_STAGES:1]   n_vld;
    logic [NUM_STAGES+1:1] w_adv;
    t_corner_adv           w_cadv;

    always_comb begin
        w_adv[NUM_STAGES+1] = m_axis_tready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        for (int k = 1; k <= NUM_STAGES; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = (k == 1) ? s_axis_tvalid : r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = w_adv[1];
    assign m_axis_tvalid = r_vld[NUM_STAGES];

    assign w_cadv.c1 = w_adv[2];
    assign w_cadv.c2 = w_adv[3];
    assign w_cadv.c3 = w_adv[4];
    assign w_cadv.c4 = w_adv[5];
    assign w_cadv.c5 = w_adv[6];
    assign w_cadv.c6 = w_adv[7];

    // ------------------------------------------------------------------
    // Stage 1: floor split of both coordinates. An arithmetic shift gives the
    // floor cell, so negative points land in the correct cell. The fraction
    // is widened to Q0.24.
    // ------------------------------------------------------------------
    logic signed [31:0] w_xin;
    logic signed [31:0] w_yin;
    logic [31:0]        w_x0;
    logic [31:0]        w_y0;
    logic [31:0]        r1_ax0;
    logic [31:0]        r1_ax1;
    logic [31:0]        r1_by0;
    logic [31:0]        r1_by1;
    logic [23:0]        r1_fx;
    logic [23:0]        r1_fy;

    assign w_xin = $signed(s_axis_tdata[31:0]);
    assign w_yin = $signed(s_axis_tdata[63:32]);
    assign w_x0  = 32'(w_xin >>> COORD_FRAC_BITS);
    assign w_y0  = 32'(w_yin >>> COORD_FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            // The corner one cell up wraps around the 32-bit lattice.
            r1_ax0 <= w_x0 ^ r_seed_x;
            r1_ax1 <= (w_x0 + 32'd1) ^ r_seed_x;
            r1_by0 <= w_y0 ^ r_seed_y;
            r1_by1 <= (w_y0 + 32'd1) ^ r_seed_y;
            r1_fx  <= 24'(s_axis_tdata[COORD_FRAC_BITS-1:0]) << (24 - COORD_FRAC_BITS);
            r1_fy  <= 24'(s_axis_tdata[32+COORD_FRAC_BITS-1:32]) << (24 - COORD_FRAC_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 7 for the four corners. The distance from the far corner is
    // the fraction minus one, which in 25 bits is the fraction with a set
    // sign bit.
    // ------------------------------------------------------------------
    logic signed [24:0] w_dx0;
    logic signed [24:0] w_dx1;
    logic signed [24:0] w_dy0;
    logic signed [24:0] w_dy1;
    logic signed [28:0] w_dot00;
    logic signed [28:0] w_dot10;
    logic signed [28:0] w_dot01;
    logic signed [28:0] w_dot11;

    assign w_dx0 = $signed({1'b0, r1_fx});
    assign w_dx1 = $signed({1'b1, r1_fx});
    assign w_dy0 = $signed({1'b0, r1_fy});
    assign w_dy1 = $signed({1'b1, r1_fy});

    gn2d_corner #(.ANGLE_BITS(ANGLE_BITS)) u_corner00 (
        .i_clk(i_clk), .i_adv(w_cadv), .i_ax(r1_ax0), .i_by(r1_by0),
        .i_dx(w_dx0), .i_dy(w_dy0), .o_dot(w_dot00)
    );
    gn2d_corner #(.ANGLE_BITS(ANGLE_BITS)) u_corner10 (
        .i_clk(i_clk), .i_adv(w_cadv), .i_ax(r1_ax1), .i_by(r1_by0),
        .i_dx(w_dx1), .i_dy(w_dy0), .o_dot(w_dot10)
    );
    gn2d_corner #(.ANGLE_BITS(ANGLE_BITS)) u_corner01 (
        .i_clk(i_clk), .i_adv(w_cadv), .i_ax(r1_ax0), .i_by(r1_by1),
        .i_dx(w_dx0), .i_dy(w_dy1), .o_dot(w_dot01)
    );
    gn2d_corner #(.ANGLE_BITS(ANGLE_BITS)) u_corner11 (
        .i_clk(i_clk), .i_adv(w_cadv), .i_ax(r1_ax1), .i_by(r1_by1),
        .i_dx(w_dx1), .i_dy(w_dy1), .o_dot(w_dot11)
    );

    // ------------------------------------------------------------------
    // Smoothstep weights, alongside the corner work: the square in stage 2,
    // the cubic term in stage 3, then a delay line up to the blends.
    // ------------------------------------------------------------------
    logic [23:0] r2_w2x;
    logic [23:0] r2_w2y;
    logic [23:0] r2_fx;
    logic [23:0] r2_fy;
    logic [24:0] r3_sx;
    logic [24:0] r3_sy;
    logic [24:0] r_sx_dly [4:7];
    logic [24:0] r_sy_dly [4:9];
    logic [25:0] w_mx;
    logic [25:0] w_my;

    assign w_mx = 26'd50331648 - {1'b0, r2_fx, 1'b0};
    assign w_my = 26'd50331648 - {1'b0, r2_fy, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_w2x <= 24'((48'(r1_fx) * 48'(r1_fx)) >> 24);
            r2_w2y <= 24'((48'(r1_fy) * 48'(r1_fy)) >> 24);
            r2_fx  <= r1_fx;
            r2_fy  <= r1_fy;
        end
        if (w_adv[3]) begin
            r3_sx <= 25'((50'(r2_w2x) * 50'(w_mx)) >> 24);
            r3_sy <= 25'((50'(r2_w2y) * 50'(w_my)) >> 24);
        end
        if (w_adv[4]) begin
            r_sx_dly[4] <= r3_sx;
            r_sy_dly[4] <= r3_sy;
        end
        for (int k = 5; k <= 7; k++) begin
            if (w_adv[k]) begin
                r_sx_dly[k] <= r_sx_dly[k-1];
            end
        end
        for (int k = 5; k <= 9; k++) begin
            if (w_adv[k]) begin
                r_sy_dly[k] <= r_sy_dly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 8 and 9: blend along x for the lower and upper rows.
    // Stages 10 and 11: blend along y. Stage 12: round to Q15 and saturate.
    // All roundings are half up, which an arithmetic shift after adding half
    // gives directly.
    // ------------------------------------------------------------------
    logic signed [25:0] w_sx;
    logic signed [25:0] w_sy;
    logic signed [29:0] w_d_lo;
    logic signed [29:0] w_d_hi;
    logic signed [55:0] r8_plo;
    logic signed [55:0] r8_phi;
    logic signed [28:0] r8_d00;
    logic signed [28:0] r8_d01;
    logic signed [29:0] r9_lo;
    logic signed [29:0] r9_hi;
    logic signed [30:0] w_d_y;
    logic signed [56:0] r10_p;
    logic signed [29:0] r10_lo;
    logic signed [31:0] r11_v;
    logic signed [31:0] w_rnd;
    logic [15:0]        n_out;

    assign w_sx   = $signed({1'b0, r_sx_dly[7]});
    assign w_sy   = $signed({1'b0, r_sy_dly[9]});
    assign w_d_lo = 30'(w_dot10) - 30'(w_dot00);
    assign w_d_hi = 30'(w_dot11) - 30'(w_dot01);
    assign w_d_y  = 31'(r9_hi) - 31'(r9_lo);
    assign w_rnd  = (r11_v + 32'sd256) >>> 9;

    always_comb begin
        if (w_rnd > 32'sd32767) begin
            n_out = 16'h7fff;
        end else if (w_rnd < -32'sd32768) begin
            n_out = 16'h8000;
        end else begin
            n_out = w_rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r8_plo <= w_d_lo * w_sx;
            r8_phi <= w_d_hi * w_sx;
            r8_d00 <= w_dot00;
            r8_d01 <= w_dot01;
        end
        if (w_adv[9]) begin
            r9_lo <= 30'(r8_d00) + 30'((r8_plo + 56'sd8388608) >>> 24);
            r9_hi <= 30'(r8_d01) + 30'((r8_phi + 56'sd8388608) >>> 24);
        end
        if (w_adv[10]) begin
            r10_p  <= w_d_y * w_sy;
            r10_lo <= r9_lo;
        end
        if (w_adv[11]) begin
            r11_v <= 32'(r10_lo) + 32'((r10_p + 57'sd8388608) >>> 24);
        end
        if (w_adv[12]) begin
            m_axis_tdata <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `GN2D_ASSERT_NEXT(a_seed_written, w_cfg_wr, r_seed == $past(pwdata))
    `GN2D_ASSERT_NEXT(a_input_lands, s_axis_tvalid && s_axis_tready, r_vld[1])
    `GN2D_ASSERT_NEXT(a_stall_keeps, r_vld[6] && !w_adv[6], r_vld[6])
    `GN2D_ASSERT_NOW(a_full_blocks, r_vld[NUM_STAGES] && r_vld[NUM_STAGES-1] && !m_axis_tready,
                     !w_adv[NUM_STAGES-1])

endmodule
